// ----- hdl/rgb2yp_pkg.sv -----
package rgb2yp_pkg;

	localparam int DataW    = 16;
	localparam int NormW    = 16;
	localparam int QuotW    = 15;
	localparam int FracW    = 15;
	localparam int ProdW    = 32;
	localparam int AccW     = ProdW - FracW;
	localparam int NumLanes = 3;
	localparam int ApbAddrW = 2;
	localparam int ApbDataW = 32;

	localparam logic [ApbAddrW-1:0] AddrMaxValue  = ApbAddrW'(0);
	localparam logic [DataW-1:0]    MaxValueReset = DataW'(255);

	localparam logic [NormW-1:0] OneQ15 = NormW'(32768);
	localparam logic signed [ProdW-1:0] RoundBias = ProdW'(16384);
	localparam logic signed [AccW-1:0] LumaMax  = AccW'(32768);
	localparam logic signed [AccW-1:0] ChromaMax = AccW'(16384);
	localparam logic signed [AccW-1:0] ChromaMin = -AccW'(16384);

	localparam int LaneRed   = 0;
	localparam int LaneGreen = 1;
	localparam int LaneBlue  = 2;

	localparam int OutY  = 0;
	localparam int OutPb = 1;
	localparam int OutPr = 2;

	typedef logic signed [15:0] coef_t;

	// rows: y, pb, pr; columns: red, green, blue
	localparam coef_t CoefTab [NumLanes][NumLanes] = '{
		'{16'sd9798,   16'sd19235,  16'sd3736},
		'{-16'sd5529,  -16'sd10855, 16'sd16384},
		'{16'sd16384,  -16'sd13720, -16'sd2664}
	};

	typedef struct packed {
		logic [DataW-1:0] red_in;
		logic [DataW-1:0] green_in;
		logic [DataW-1:0] blue_in;
	} pixel_t;

	typedef struct packed {
		logic [DataW-1:0]        luma_out;
		logic signed [DataW-1:0] blue_diff_out;
		logic signed [DataW-1:0] red_diff_out;
	} result_t;

	typedef logic [NormW-1:0] norm_t;
	typedef norm_t [NumLanes-1:0] norm_vec_t;

endpackage

// ----- hdl/rgb_to_ypbpr_converter.sv -----
// rgb to ypbpr color converter, bt.601, q15 fixed point (32768 = 1.0)
// request channel: pixel carries red_in, green_in, blue_in; a request is
//   taken at a clock edge with start high and busy low. busy stays low, so a
//   new pixel may be issued every cycle.
// result channel: done is high for exactly one cycle while result holds
//   luma_out, blue_diff_out and red_diff_out; the receiver cannot stall and
//   no hold-off exists.
// pipeline: after the request edge the result passes through one capture
//   stage, 15 stages of the restoring divider that normalizes
//   each component by max_value (one quotient bit per stage), then a
//   multiply stage, a sum-and-round stage and a clamp stage.
// throughput: one pixel per cycle, results in request order.
// configuration: apb, max_value read at address 0, written at any address,
//   reset 255; write it only while no request is in flight. zero acts as one.
// reset: arst_n clears all pipeline valids and restores max_value; items in
//   flight are dropped.
module rgb_to_ypbpr_converter
	import rgb2yp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  pixel_t              pixel,
	output logic                done,
	output result_t             result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [ApbDataW-1:0] pwdata,
	output logic [ApbDataW-1:0] prdata,
	output logic                pready
);

	logic [DataW-1:0] max_value_q;
	logic [DataW-1:0] denom;
	logic             accept;
	logic             norm_vld;
	norm_vec_t        norm;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_value_q <= MaxValueReset;
		end else if (psel && penable && pwrite && pready) begin
			max_value_q <= pwdata[DataW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == AddrMaxValue) begin
			prdata = {{(ApbDataW-DataW){1'b0}}, max_value_q};
		end
	end

	assign denom = (max_value_q == '0) ? DataW'(1) : max_value_q;

	rgb2yp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (accept),
		.pixel   (pixel),
		.denom   (denom),
		.out_vld (norm_vld),
		.norm    (norm)
	);

	rgb2yp_matrix u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (norm_vld),
		.norm    (norm),
		.out_vld (done),
		.result  (result)
	);

endmodule

// ----- hdl/rgb2yp_div.sv -----
module rgb2yp_div
	import rgb2yp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  pixel_t           pixel,
	input  logic [DataW-1:0] denom,
	output logic             out_vld,
	output norm_vec_t        norm
);

	logic [DataW-1:0] raw [NumLanes];
	logic [DataW-1:0] rem_s  [0:QuotW][NumLanes];
	logic [QuotW-1:0] quot_s [0:QuotW][NumLanes];
	logic             sat_s  [0:QuotW][NumLanes];
	logic             vld_s  [0:QuotW];

	logic [DataW:0]   trial   [1:QuotW][NumLanes];
	logic [DataW:0]   diff    [1:QuotW][NumLanes];
	logic             ge      [1:QuotW][NumLanes];
	logic [DataW-1:0] rem_nxt [1:QuotW][NumLanes];

	always_comb begin
		raw[LaneRed]   = pixel.red_in;
		raw[LaneGreen] = pixel.green_in;
		raw[LaneBlue]  = pixel.blue_in;
	end

	// one quotient bit per stage; the low dividend bits are denom/2
	always_comb begin
		for (int k = 1; k <= QuotW; k++) begin
			for (int l = 0; l < NumLanes; l++) begin
				trial[k][l]   = {rem_s[k-1][l], denom[QuotW-k+1]};
				diff[k][l]    = trial[k][l] - {1'b0, denom};
				ge[k][l]      = trial[k][l] >= {1'b0, denom};
				rem_nxt[k][l] = ge[k][l] ? diff[k][l][DataW-1:0] : trial[k][l][DataW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QuotW; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[0] <= in_vld;
			for (int k = 1; k <= QuotW; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < NumLanes; l++) begin
			rem_s[0][l]  <= raw[l];
			quot_s[0][l] <= '0;
			sat_s[0][l]  <= raw[l] >= denom;
			for (int k = 1; k <= QuotW; k++) begin
				rem_s[k][l]  <= rem_nxt[k][l];
				quot_s[k][l] <= {quot_s[k-1][l][QuotW-2:0], ge[k][l]};
				sat_s[k][l]  <= sat_s[k-1][l];
			end
		end
	end

	always_comb begin
		out_vld = vld_s[QuotW];
		for (int l = 0; l < NumLanes; l++) begin
			norm[l] = sat_s[QuotW][l] ? OneQ15 : {1'b0, quot_s[QuotW][l]};
		end
	end

endmodule

// ----- hdl/rgb2yp_matrix.sv -----
module rgb2yp_matrix
	import rgb2yp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_vld,
	input  norm_vec_t norm,
	output logic      out_vld,
	output result_t   result
);

	logic signed [ProdW-1:0] prod_s1 [NumLanes][NumLanes];
	logic signed [AccW-1:0]  acc_s2  [NumLanes];
	result_t                 result_s3;
	logic                    vld_s1, vld_s2, vld_s3;

	logic signed [ProdW-1:0] sum [NumLanes];
	logic signed [AccW-1:0]  luma_c, pb_c, pr_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_comb begin
		for (int o = 0; o < NumLanes; o++) begin
			sum[o] = prod_s1[o][LaneRed] + prod_s1[o][LaneGreen] + prod_s1[o][LaneBlue]
				+ RoundBias;
		end
	end

	// clamp the rounded sums
	always_comb begin
		luma_c = acc_s2[OutY];
		if (acc_s2[OutY] < 0) begin
			luma_c = '0;
		end else if (acc_s2[OutY] > LumaMax) begin
			luma_c = LumaMax;
		end
		pb_c = acc_s2[OutPb];
		if (acc_s2[OutPb] < ChromaMin) begin
			pb_c = ChromaMin;
		end else if (acc_s2[OutPb] > ChromaMax) begin
			pb_c = ChromaMax;
		end
		pr_c = acc_s2[OutPr];
		if (acc_s2[OutPr] < ChromaMin) begin
			pr_c = ChromaMin;
		end else if (acc_s2[OutPr] > ChromaMax) begin
			pr_c = ChromaMax;
		end
	end

	always_ff @(posedge clk) begin
		for (int o = 0; o < NumLanes; o++) begin
			for (int l = 0; l < NumLanes; l++) begin
				prod_s1[o][l] <= ProdW'($signed({1'b0, norm[l]})) * ProdW'(CoefTab[o][l]);
			end
			acc_s2[o] <= sum[o][ProdW-1:FracW];
		end
		result_s3.luma_out      <= luma_c[DataW-1:0];
		result_s3.blue_diff_out <= pb_c[DataW-1:0];
		result_s3.red_diff_out  <= pr_c[DataW-1:0];
	end

	assign out_vld = vld_s3;
	assign result  = result_s3;

endmodule
